// ===== rtl/core/sync_length_xor_deframer_core_macros.svh =====
// Assertion macros for the deframer core.
// All uses assume the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef SYNC_LENGTH_XOR_DEFRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_XOR_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SLXD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// next-cycle implication
`define SLXD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define SLXD_ASSERT(label, ante, cons)
`define SLXD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/slxd_pkg.sv =====
package slxd_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int OUT_BYTES = 8;
    localparam int WORD_W    = 64;

    localparam int ROWS   = (BUF_DEPTH + OUT_BYTES - 1) / OUT_BYTES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LANE_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] MIN_LEN   = 8'd3;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

    localparam logic [1:0] OUTQ_DEPTH = 2'd2;

    typedef logic [OUT_BYTES-1:0][7:0] t_row;

    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  row;
        logic [LANE_W-1:0] lane;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
    } t_rd;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] word;
        logic [3:0]        count;
        logic              last;
    } t_res;

endpackage

// ===== rtl/core/sync_length_xor_deframer_core.sv =====
// Byte-stream deframer with XOR checksum.
// Input channel (i_in_valid / o_in_ready / i_rx_byte): one stream byte per
// transfer. The core hunts for sync 0x55, takes the next byte as total length N,
// then N-3 payload bytes and a checksum byte. Bytes are taken at one per cycle
// while a frame is collected, save that the length byte waits for queue room.
// Output channel (o_out_valid / i_out_ready): a frame that passes the checksum
// is sent as ceil(N/8) words, first byte in bits 7..0, unused bytes zero,
// o_last on the final word. A failed checksum drops the frame with no output.
// A length below 3 yields one word with o_kind set, the length byte in
// o_frame_word, o_byte_count 1 and o_last 1.
// After the checksum transfer the core enters the emit phase; each word is read
// from the frame store into a register, then pushed into the output queue.
// Words follow one per cycle while the queue has room. Input is held off while
// a frame is read out; the single read port of the frame store sets the output rate.
// A 2-entry output queue decouples the receiver; when it stalls, store reads
// pause and, during readout, input stays held off. The length byte waits
// for queue room.
// Reset (synchronous, i_rst_n low) returns to sync hunt with an empty queue;
// the frame store needs no clearing.
module sync_length_xor_deframer_core
    import slxd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [63:0] o_frame_word,
    output logic [3:0]  o_byte_count,
    output logic        o_last
);

`include "sync_length_xor_deframer_core_macros.svh"

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_BODY = 5'b00100,
        PH_SUM  = 5'b01000,
        PH_EMIT = 5'b10000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_idx, n_idx;
    logic [7:0]        r_xor, n_xor;
    logic [ROW_W-1:0]  r_wrow, n_wrow;
    logic [LANE_W-1:0] r_wlane, n_wlane;
    logic [ROW_W-1:0]  r_rrow, n_rrow;
    logic [7:0]        r_rem, n_rem;
    logic              r_pvalid, n_pvalid;
    logic [3:0]        r_pcnt, n_pcnt;
    logic              r_plast, n_plast;

    t_wr        wr;
    t_rd        rd;
    t_row       rdata;
    logic       accept, pop, space, err_push, push_valid, rd_issue;
    t_res       err_res, data_res, push_res, head;
    logic [1:0] fifo_cnt;
    logic [2:0] occ;
    logic [ROW_W-1:0]  pos_row;
    logic [LANE_W-1:0] pos_lane;
    logic [8:0]        idx_next2;
    logic [3:0]        iss_cnt;

    slxd_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_rdata (rdata)
    );

    slxd_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_valid),
        .i_push_data (push_res),
        .i_pop       (pop),
        .o_valid     (o_out_valid),
        .o_head      (head),
        .o_count     (fifo_cnt)
    );

    assign pop   = o_out_valid & i_out_ready;
    assign occ   = {1'b0, fifo_cnt} + {2'b00, r_pvalid} - {2'b00, pop};
    assign space = (occ < 3'({1'b0, OUTQ_DEPTH}));

    always_comb begin
        case (r_phase)
            PH_HUNT, PH_BODY, PH_SUM: o_in_ready = 1'b1;
            PH_LEN:                   o_in_ready = space;
            default:                  o_in_ready = 1'b0;
        endcase
    end

    assign accept = i_in_valid & o_in_ready;

    // write pointer: sync always lands at the first slot
    assign pos_row  = (r_phase == PH_HUNT) ? '0 : r_wrow;
    assign pos_lane = (r_phase == PH_HUNT) ? '0 : r_wlane;
    assign idx_next2 = {1'b0, r_idx} + 9'd2;
    assign iss_cnt = ({1'b0, r_rem} > 9'(OUT_BYTES)) ? 4'(OUT_BYTES) : r_rem[3:0];
    assign rd_issue = (r_phase == PH_EMIT) && space;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_idx    = r_idx;
        n_xor    = r_xor;
        n_wrow   = r_wrow;
        n_wlane  = r_wlane;
        n_rrow   = r_rrow;
        n_rem    = r_rem;
        n_pvalid = 1'b0;
        n_pcnt   = r_pcnt;
        n_plast  = r_plast;
        err_push = 1'b0;
        wr.en    = 1'b0;
        wr.row   = pos_row;
        wr.lane  = pos_lane;
        wr.data  = i_rx_byte;
        rd.en    = rd_issue;
        rd.row   = r_rrow;

        if (accept && r_phase != PH_HUNT) begin
            // default advance of the write pointer for stored bytes
            if (pos_lane == LANE_W'(OUT_BYTES - 1)) begin
                n_wlane = '0;
                n_wrow  = pos_row + 1'b1;
            end else begin
                n_wlane = pos_lane + 1'b1;
            end
        end

        case (r_phase)
            PH_HUNT: begin
                if (accept && i_rx_byte == SYNC_BYTE) begin
                    wr.en   = 1'b1;
                    n_xor   = SYNC_BYTE;
                    n_idx   = 8'd1;
                    n_phase = PH_LEN;
                    if (OUT_BYTES == 1) begin
                        n_wrow  = ROW_W'(1);
                        n_wlane = '0;
                    end else begin
                        n_wrow  = '0;
                        n_wlane = LANE_W'(1);
                    end
                end
            end
            PH_LEN: begin
                if (accept) begin
                    if (i_rx_byte < MIN_LEN || {1'b0, i_rx_byte} > 9'(BUF_DEPTH)) begin
                        err_push = 1'b1;
                        n_idx    = '0;
                        n_phase  = PH_HUNT;
                    end else begin
                        wr.en   = 1'b1;
                        n_len   = i_rx_byte;
                        n_xor   = r_xor ^ i_rx_byte;
                        n_idx   = 8'd2;
                        n_phase = (i_rx_byte == MIN_LEN) ? PH_SUM : PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (accept) begin
                    wr.en = 1'b1;
                    n_xor = r_xor ^ i_rx_byte;
                    n_idx = r_idx + 8'd1;
                    if (idx_next2 >= {1'b0, r_len}) begin
                        n_phase = PH_SUM;
                    end
                end
            end
            PH_SUM: begin
                if (accept) begin
                    // checksum sits at position N-1, the current pointer
                    wr.en = 1'b1;
                    n_idx = '0;
                    if (i_rx_byte == r_xor) begin
                        n_phase = PH_EMIT;
                        n_rem   = r_len;
                        n_rrow  = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_EMIT: begin
                if (rd_issue) begin
                    n_pvalid = 1'b1;
                    n_pcnt   = iss_cnt;
                    n_plast  = ({1'b0, r_rem} <= 9'(OUT_BYTES));
                    n_rem    = r_rem - {4'd0, iss_cnt};
                    n_rrow   = r_rrow + 1'b1;
                    if ({1'b0, r_rem} <= 9'(OUT_BYTES)) begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_len    <= '0;
            r_idx    <= '0;
            r_xor    <= '0;
            r_wrow   <= '0;
            r_wlane  <= '0;
            r_rrow   <= '0;
            r_rem    <= '0;
            r_pvalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_xor    <= n_xor;
            r_wrow   <= n_wrow;
            r_wlane  <= n_wlane;
            r_rrow   <= n_rrow;
            r_rem    <= n_rem;
            r_pvalid <= n_pvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcnt  <= n_pcnt;
        r_plast <= n_plast;
    end

    // bytes past the frame end in the last row are zeroed
    always_comb begin
        data_res.kind  = KIND_DATA;
        data_res.word  = '0;
        data_res.count = r_pcnt;
        data_res.last  = r_plast;
        for (int k = 0; k < OUT_BYTES; k++) begin
            if (4'(k) < r_pcnt) begin
                data_res.word[k*8 +: 8] = rdata[k];
            end
        end
    end

    always_comb begin
        err_res.kind  = KIND_ERR;
        err_res.word  = {{(WORD_W - 8){1'b0}}, i_rx_byte};
        err_res.count = 4'd1;
        err_res.last  = 1'b1;
    end

    assign push_valid = r_pvalid | err_push;
    assign push_res   = r_pvalid ? data_res : err_res;

    assign o_kind       = head.kind;
    assign o_frame_word = head.word;
    assign o_byte_count = head.count;
    assign o_last       = head.last;

    `SLXD_ASSERT(a_no_push_collision, r_pvalid, !err_push)
    `SLXD_ASSERT(a_queue_no_overflow, push_valid, (fifo_cnt != OUTQ_DEPTH) || pop)
    `SLXD_ASSERT_NEXT(a_emit_ends_in_hunt, rd_issue && n_plast, r_phase == PH_HUNT)

endmodule

// ===== rtl/core/slxd_store.sv =====
module slxd_store
    import slxd_pkg::*;
(
    input  logic i_clk,
    input  t_wr  i_wr,
    input  t_rd  i_rd,
    output t_row o_rdata
);

    // one row holds one output word; bytes land through lane enables
    t_row r_mem [ROWS];
    t_row r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.row][i_wr.lane] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.row];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/slxd_outq.sv =====
module slxd_outq
    import slxd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_res       i_push_data,
    input  logic       i_pop,
    output logic       o_valid,
    output t_res       o_head,
    output logic [1:0] o_count
);

    t_res       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_push_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_ent[r_rp];
    assign o_count = r_cnt;

endmodule
